// ===== hdl/pcc_pkg.sv =====
// Shared constants, codes and types of the page cache tag store with clock replacement.
package pcc_pkg;

    // Default geometry, handed down as parameters from the top level.
    localparam int SLOTS_DEFAULT      = 16;
    localparam int PAGE_BITS_DEFAULT  = 20;
    localparam int FRAME_BITS_DEFAULT = 16;

    // Request field and configuration port widths.
    localparam int OP_BITS      = 2;
    localparam int ENTRIES_BITS = 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 5;

    // Request opcodes.
    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MARK   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRIES = 1'd1;

    // Reset values of the configuration registers.
    localparam logic                    POLICY_RESET  = 1'b0;
    localparam logic [ENTRIES_BITS-1:0] ENTRIES_RESET = 5'd16;

    // Replacement policy codes.
    localparam logic POLICY_CLOCK   = 1'b0;
    localparam logic POLICY_CLOCK_M = 1'b1;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic                    policy;
        logic [ENTRIES_BITS-1:0] entries;
    } pcc_cfg_t;

endpackage

// ===== hdl/pcc_tag_ram.sv =====
// Tag memory: page number and frame of every slot, one write and one registered read port.
module pcc_tag_ram
    import pcc_pkg::*;
#(
    parameter int DEPTH     = SLOTS_DEFAULT,
    parameter int WIDTH     = PAGE_BITS_DEFAULT + FRAME_BITS_DEFAULT,
    parameter int ADDR_BITS = $clog2(SLOTS_DEFAULT)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pcc_seq.sv =====
// Request sequencer: shared tag comparator walk, clock hand sweep, status bits and result register.
module pcc_seq
    import pcc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEFAULT,
    parameter int PAGE_BITS  = PAGE_BITS_DEFAULT,
    parameter int FRAME_BITS = FRAME_BITS_DEFAULT,
    parameter int SLOT_BITS  = $clog2(SLOTS_DEFAULT)
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pcc_cfg_t                        cfg,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [OP_BITS-1:0]              opcode,
    input  logic [PAGE_BITS-1:0]            page_number,
    input  logic [FRAME_BITS-1:0]           frame_in,
    output logic [SLOT_BITS-1:0]            mem_rd_addr,
    input  logic [PAGE_BITS+FRAME_BITS-1:0] mem_rd_data,
    output logic                            mem_wr_en,
    output logic [SLOT_BITS-1:0]            mem_wr_addr,
    output logic [PAGE_BITS+FRAME_BITS-1:0] mem_wr_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            hit,
    output logic [SLOT_BITS-1:0]            slot,
    output logic [FRAME_BITS-1:0]           frame_out,
    output logic                            write_back,
    output logic [PAGE_BITS-1:0]            victim_page,
    output logic [FRAME_BITS-1:0]           victim_frame,
    output logic                            miss_fault
);

    localparam int CNT_BITS = SLOT_BITS + 1;
    localparam int CMP_BITS = (CNT_BITS > ENTRIES_BITS) ? CNT_BITS : ENTRIES_BITS;
    localparam int TAG_BITS = PAGE_BITS + FRAME_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_MISS   = 6'b000100,
        ST_FILL   = 6'b001000,
        ST_SWEEP  = 6'b010000,
        ST_EVICT  = 6'b100000
    } state_t;

    state_t                  state_reg,       state_next;
    logic [OP_BITS-1:0]      op_reg,          op_next;
    logic [PAGE_BITS-1:0]    page_reg,        page_next;
    logic [FRAME_BITS-1:0]   frame_reg,       frame_next;
    logic [SLOT_BITS-1:0]    idx_reg,         idx_next;
    logic [CNT_BITS-1:0]     fill_reg,        fill_next;
    logic [SLOT_BITS-1:0]    hand_reg,        hand_next;
    logic [CNT_BITS-1:0]     pass_cnt_reg,    pass_cnt_next;
    logic                    second_pass_reg, second_pass_next;
    logic [SLOTS-1:0]        use_reg,         use_next;
    logic [SLOTS-1:0]        dirty_reg,       dirty_next;

    logic                    rsp_valid_reg,   rsp_valid_next;
    logic                    hit_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [FRAME_BITS-1:0]   frame_out_reg;
    logic                    write_back_reg;
    logic [PAGE_BITS-1:0]    victim_page_reg;
    logic [FRAME_BITS-1:0]   victim_frame_reg;
    logic                    miss_fault_reg;

    logic                    res_load;
    logic                    res_hit;
    logic [SLOT_BITS-1:0]    res_slot;
    logic [FRAME_BITS-1:0]   res_frame;
    logic                    res_wb;
    logic [PAGE_BITS-1:0]    res_vpage;
    logic [FRAME_BITS-1:0]   res_vframe;
    logic                    res_fault;

    logic [CMP_BITS-1:0]     entries_ext;
    logic [CNT_BITS-1:0]     active_n;
    logic [PAGE_BITS-1:0]    rd_page;
    logic [FRAME_BITS-1:0]   rd_frame;
    logic                    tag_match;
    logic [CNT_BITS-1:0]     idx_inc;
    logic [CNT_BITS-1:0]     hand_inc;
    logic [SLOT_BITS-1:0]    hand_adv;
    logic [CNT_BITS-1:0]     pass_inc;
    logic                    load_ok;
    logic                    cur_use;
    logic                    cur_dirty;

    // Active slot count, clamped to one through SLOTS.
    always_comb
    begin
        entries_ext = CMP_BITS'(cfg.entries);
        if (entries_ext == '0)
        begin
            active_n = CNT_BITS'(1);
        end
        else if (entries_ext > CMP_BITS'(SLOTS))
        begin
            active_n = CNT_BITS'(SLOTS);
        end
        else
        begin
            active_n = CNT_BITS'(entries_ext);
        end
    end

    assign rd_page   = mem_rd_data[TAG_BITS-1:FRAME_BITS];
    assign rd_frame  = mem_rd_data[FRAME_BITS-1:0];
    assign tag_match = (rd_page == page_reg);
    assign idx_inc   = {1'b0, idx_reg} + CNT_BITS'(1);
    assign hand_inc  = {1'b0, hand_reg} + CNT_BITS'(1);
    assign hand_adv  = (hand_inc == active_n) ? '0 : hand_inc[SLOT_BITS-1:0];
    assign pass_inc  = pass_cnt_reg + CNT_BITS'(1);
    assign load_ok   = !rsp_valid_reg || !rsp_stall;
    assign cur_use   = use_reg[hand_reg];
    assign cur_dirty = dirty_reg[hand_reg];

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        page_next        = page_reg;
        frame_next       = frame_reg;
        idx_next         = idx_reg;
        fill_next        = fill_reg;
        hand_next        = hand_reg;
        pass_cnt_next    = pass_cnt_reg;
        second_pass_next = second_pass_reg;
        use_next         = use_reg;
        dirty_next       = dirty_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = hand_reg;
        mem_wr_data      = {page_reg, frame_reg};
        res_load         = 1'b0;
        res_hit          = 1'b0;
        res_slot         = '0;
        res_frame        = '0;
        res_wb           = 1'b0;
        res_vpage        = '0;
        res_vframe       = '0;
        res_fault        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = opcode;
                    page_next  = page_number;
                    frame_next = frame_in;
                    idx_next   = '0;
                    if (opcode != OP_INSERT)
                    begin
                        state_next = (fill_reg == '0) ? ST_MISS : ST_SEARCH;
                    end
                    else if (fill_reg < active_n)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        if ({1'b0, hand_reg} >= active_n)
                        begin
                            hand_next = '0;
                        end
                        pass_cnt_next    = '0;
                        second_pass_next = 1'b0;
                        state_next       = ST_SWEEP;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (tag_match)
                begin
                    if (load_ok)
                    begin
                        res_load  = 1'b1;
                        res_hit   = 1'b1;
                        res_slot  = idx_reg;
                        res_frame = rd_frame;
                        if (op_reg == OP_LOOKUP || op_reg == OP_WRITE)
                        begin
                            use_next[idx_reg] = 1'b1;
                        end
                        if (op_reg == OP_WRITE || op_reg == OP_MARK)
                        begin
                            dirty_next[idx_reg] = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_inc == fill_reg)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    idx_next = idx_inc[SLOT_BITS-1:0];
                end
            end

            ST_MISS:
            begin
                if (load_ok)
                begin
                    res_load   = 1'b1;
                    res_fault  = (op_reg == OP_WRITE);
                    state_next = ST_IDLE;
                end
            end

            ST_FILL:
            begin
                if (load_ok)
                begin
                    res_load    = 1'b1;
                    res_slot    = fill_reg[SLOT_BITS-1:0];
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = fill_reg[SLOT_BITS-1:0];
                    use_next[fill_reg[SLOT_BITS-1:0]]   = 1'b1;
                    dirty_next[fill_reg[SLOT_BITS-1:0]] = 1'b0;
                    fill_next   = fill_reg + CNT_BITS'(1);
                    state_next  = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                if (cfg.policy == POLICY_CLOCK)
                begin
                    if (!cur_use)
                    begin
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        use_next[hand_reg] = 1'b0;
                        hand_next          = hand_adv;
                    end
                end
                else if (!second_pass_reg)
                begin
                    // First pass looks for a slot that is neither used nor modified.
                    if (!cur_use && !cur_dirty)
                    begin
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        hand_next = hand_adv;
                        if (pass_inc == active_n)
                        begin
                            second_pass_next = 1'b1;
                            pass_cnt_next    = '0;
                        end
                        else
                        begin
                            pass_cnt_next = pass_inc;
                        end
                    end
                end
                else
                begin
                    // Second pass takes an unused modified slot and clears use bits.
                    if (!cur_use && cur_dirty)
                    begin
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        use_next[hand_reg] = 1'b0;
                        hand_next          = hand_adv;
                        if (pass_inc == active_n)
                        begin
                            second_pass_next = 1'b0;
                            pass_cnt_next    = '0;
                        end
                        else
                        begin
                            pass_cnt_next = pass_inc;
                        end
                    end
                end
            end

            ST_EVICT:
            begin
                if (load_ok)
                begin
                    res_load   = 1'b1;
                    res_slot   = hand_reg;
                    res_wb     = cur_dirty;
                    res_vpage  = rd_page;
                    res_vframe = rd_frame;
                    mem_wr_en  = 1'b1;
                    use_next[hand_reg]   = 1'b1;
                    dirty_next[hand_reg] = 1'b0;
                    hand_next  = hand_adv;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The read address follows the slot that the next cycle examines.
    assign mem_rd_addr = (state_reg == ST_SWEEP || state_reg == ST_EVICT) ? hand_next : idx_next;

    always_comb
    begin
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            hand_reg        <= '0;
            pass_cnt_reg    <= '0;
            second_pass_reg <= 1'b0;
            use_reg         <= '0;
            dirty_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            hand_reg        <= hand_next;
            pass_cnt_reg    <= pass_cnt_next;
            second_pass_reg <= second_pass_next;
            use_reg         <= use_next;
            dirty_reg       <= dirty_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        page_reg  <= page_next;
        frame_reg <= frame_next;
        idx_reg   <= idx_next;
        if (res_load)
        begin
            hit_reg          <= res_hit;
            slot_reg         <= res_slot;
            frame_out_reg    <= res_frame;
            write_back_reg   <= res_wb;
            victim_page_reg  <= res_vpage;
            victim_frame_reg <= res_vframe;
            miss_fault_reg   <= res_fault;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign frame_out    = frame_out_reg;
    assign write_back   = write_back_reg;
    assign victim_page  = victim_page_reg;
    assign victim_frame = victim_frame_reg;
    assign miss_fault   = miss_fault_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_BITS'(SLOTS))
        else $error("fill count exceeds the slot count");

    a_search_in_filled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> {1'b0, idx_reg} < fill_reg)
        else $error("tag walk left the filled slots");

    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> {1'b0, hand_reg} < active_n)
        else $error("clock hand outside the active slots during a sweep");

    a_victim_unused: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVICT |-> !use_reg[hand_reg])
        else $error("victim slot still has its use bit set");

    a_fault_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && miss_fault_reg |-> !hit_reg)
        else $error("result reports a hit and a write miss at once");

endmodule

// ===== hdl/page_cache_clock_replacement.sv =====
// Top level of the page cache tag store: configuration registers, tag memory and sequencer.
//
// Requests enter on req_valid/req_stall with opcode, page_number and frame_in; an item is
// taken at a clock edge with req_valid high and req_stall low. Every request gives exactly
// one result item on rsp_valid/rsp_stall. Configuration is written on cfg_valid/cfg_ready
// (cfg_ready is always high): index 0 selects the policy, index 1 the active slot count.
//
// One request is worked at a time; req_stall is high from acceptance until its result is
// loaded into the result register. A single tag comparator walks the filled slots one per
// cycle until a lookup, write or mark hits a slot or misses after the last filled slot. An
// eviction walks the clock hand one slot per cycle over the status bits, under plain clock
// or the enhanced policy, until it finds a victim among the active slots. A new request
// can be accepted while the previous result still waits in the result register; if the
// receiver stalls, the sequencer holds in its final step until the register frees up.
// Reset clears the use and modified bits, the fill count and the hand; tag contents are
// meaningless until a slot is filled, which needs no clearing pass.
module page_cache_clock_replacement
    import pcc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEFAULT,
    parameter int PAGE_BITS  = PAGE_BITS_DEFAULT,
    parameter int FRAME_BITS = FRAME_BITS_DEFAULT,
    parameter int SLOT_BITS  = $clog2(SLOTS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DAT_BITS-1:0] cfg_data,

    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [OP_BITS-1:0]      opcode,
    input  logic [PAGE_BITS-1:0]    page_number,
    input  logic [FRAME_BITS-1:0]   frame_in,

    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    hit,
    output logic [SLOT_BITS-1:0]    slot,
    output logic [FRAME_BITS-1:0]   frame_out,
    output logic                    write_back,
    output logic [PAGE_BITS-1:0]    victim_page,
    output logic [FRAME_BITS-1:0]   victim_frame,
    output logic                    miss_fault
);

    localparam int TAG_BITS = PAGE_BITS + FRAME_BITS;

    // Configuration registers. Writes must only be issued while the block is idle, so the
    // sequencer sees a steady value during a request; the block itself does not enforce this.
    logic                    policy_reg,  policy_next;
    logic [ENTRIES_BITS-1:0] entries_reg, entries_next;
    pcc_cfg_t                cfg;

    logic [SLOT_BITS-1:0]    mem_rd_addr;
    logic [TAG_BITS-1:0]     mem_rd_data;
    logic                    mem_wr_en;
    logic [SLOT_BITS-1:0]    mem_wr_addr;
    logic [TAG_BITS-1:0]     mem_wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        policy_next  = policy_reg;
        entries_next = entries_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_POLICY:  policy_next  = cfg_data[0];
                CFG_ENTRIES: entries_next = cfg_data[ENTRIES_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POLICY_RESET;
            entries_reg <= ENTRIES_RESET;
        end
        else
        begin
            policy_reg  <= policy_next;
            entries_reg <= entries_next;
        end
    end

    assign cfg.policy  = policy_reg;
    assign cfg.entries = entries_reg;

    // Page number and frame of each slot live in a single-port-read memory.
    pcc_tag_ram #(
        .DEPTH     (SLOTS),
        .WIDTH     (TAG_BITS),
        .ADDR_BITS (SLOT_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The sequencer owns the status bits, the fill count, the clock hand and the result.
    pcc_seq #(
        .SLOTS      (SLOTS),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS),
        .SLOT_BITS  (SLOT_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .page_number  (page_number),
        .frame_in     (frame_in),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .hit          (hit),
        .slot         (slot),
        .frame_out    (frame_out),
        .write_back   (write_back),
        .victim_page  (victim_page),
        .victim_frame (victim_frame),
        .miss_fault   (miss_fault)
    );

endmodule
